// File: hw/rtl/mpe_pkg.sv
package mpe_pkg;

   localparam int unsigned DATA_W        = 16;
   localparam int unsigned PROD_W        = 2 * DATA_W;
   localparam int unsigned CNT_W         = 3;
   localparam int unsigned CSR_IDX_W     = 3;
   localparam int unsigned NUM_COEFS     = 6;
   localparam int unsigned MAX_TERMS_DEF = 6;

   localparam logic [DATA_W-1:0] MODULUS_RST    = 16'd10079;
   localparam logic [CNT_W-1:0]  TERM_COUNT_RST = 3'd3;
   localparam logic [DATA_W-1:0] COEF_RST       = 16'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODULUS    = 3'd0,
      CSR_TERM_COUNT = 3'd1,
      CSR_COEF_ZERO  = 3'd2,
      CSR_COEF_ONE   = 3'd3,
      CSR_COEF_TWO   = 3'd4,
      CSR_COEF_THREE = 3'd5,
      CSR_COEF_FOUR  = 3'd6,
      CSR_COEF_FIVE  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [DATA_W-1:0]                  modulus;
      logic [CNT_W-1:0]                   term_count;
      logic [NUM_COEFS-1:0][DATA_W-1:0]   coef;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } rem_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] remainder;
   } rem_rsp_type;

endpackage

// File: hw/rtl/modular_polynomial_eval.sv
// each term but the last takes two passes of the 32-step bit-serial remainder unit,
// coefficient times power and then power times point; the last term takes the first only
// a zero modulus or term count gives a zero result without using the unit
// not ready for a new point while an item is at work
// reset: synchronous, active high; registers return to modulus 10079, three terms,
// all coefficients zero
module modular_polynomial_eval #(
   parameter int unsigned MAX_TERMS = mpe_pkg::MAX_TERMS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [mpe_pkg::DATA_W-1:0]    req_point,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mpe_pkg::DATA_W-1:0]    rsp_share_value,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mpe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mpe_pkg::DATA_W-1:0]    csr_data
);
   import mpe_pkg::*;

   cfg_type     cfg;
   rem_req_type rem_req;
   rem_rsp_type rem_rsp;

   mpe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mpe_rem u_rem (
      .clock   (clock),
      .reset   (reset),
      .rem_req (rem_req),
      .rem_rsp (rem_rsp)
   );

   mpe_ctrl #(
      .MAX_TERMS (MAX_TERMS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_point       (req_point),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_share_value (rsp_share_value),
      .rem_req         (rem_req),
      .rem_rsp         (rem_rsp)
   );

endmodule

// File: hw/rtl/mpe_csr.sv
module mpe_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mpe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mpe_pkg::DATA_W-1:0]        csr_data,
   output mpe_pkg::cfg_type                  cfg
);
   import mpe_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_MODULUS:    cfg_in.modulus    = csr_data;
            CSR_TERM_COUNT: cfg_in.term_count = csr_data[CNT_W-1:0];
            CSR_COEF_ZERO:  cfg_in.coef[0]    = csr_data;
            CSR_COEF_ONE:   cfg_in.coef[1]    = csr_data;
            CSR_COEF_TWO:   cfg_in.coef[2]    = csr_data;
            CSR_COEF_THREE: cfg_in.coef[3]    = csr_data;
            CSR_COEF_FOUR:  cfg_in.coef[4]    = csr_data;
            CSR_COEF_FIVE:  cfg_in.coef[5]    = csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.modulus    <= MODULUS_RST;
         cfg_ff.term_count <= TERM_COUNT_RST;
         for (int k = 0; k < NUM_COEFS; k++) begin
            cfg_ff.coef[k] <= COEF_RST;
         end
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hw/rtl/mpe_rem.sv
module mpe_rem (
   input  logic                  clock,
   input  logic                  reset,
   input  mpe_pkg::rem_req_type  rem_req,
   output mpe_pkg::rem_rsp_type  rem_rsp
);
   import mpe_pkg::*;

   localparam int unsigned STEP_W = $clog2(PROD_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [PROD_W-1:0] dvd_ff, dvd_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic [DATA_W:0]   trial;
   logic [DATA_W:0]   diff;

   assign trial = {rem_ff, dvd_ff[PROD_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   assign rem_rsp.done      = done_ff;
   assign rem_rsp.remainder = rem_ff;

   // one quotient bit per cycle, remainder kept
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (busy_ff) begin
         dvd_in  = dvd_ff << 1;
         rem_in  = diff[DATA_W] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(PROD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (rem_req.start) begin
         dvd_in  = rem_req.dividend;
         dvs_in  = rem_req.divisor;
         rem_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

endmodule

// File: hw/rtl/mpe_ctrl.sv
module mpe_ctrl #(
   parameter int unsigned MAX_TERMS = mpe_pkg::MAX_TERMS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mpe_pkg::cfg_type              cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [mpe_pkg::DATA_W-1:0]    req_point,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mpe_pkg::DATA_W-1:0]    rsp_share_value,
   output mpe_pkg::rem_req_type          rem_req,
   input  mpe_pkg::rem_rsp_type          rem_rsp
);
   import mpe_pkg::*;

   localparam int unsigned IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam logic [CNT_W-1:0] TERM_LIMIT = CNT_W'(MAX_TERMS);

   typedef enum logic [4:0] {
      S_IDLE      = 5'b00001,
      S_COEF      = 5'b00010,
      S_COEF_WAIT = 5'b00100,
      S_POW_WAIT  = 5'b01000,
      S_DONE      = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [DATA_W-1:0] x_ff, x_in;
   logic [DATA_W-1:0] pw_ff, pw_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] share_ff, share_in;

   logic [CNT_W-1:0]  n_sat;
   logic [DATA_W-1:0] coef_sel;
   logic [DATA_W-1:0] mul_a;
   logic [PROD_W-1:0] product;
   logic [DATA_W:0]   sum;
   logic [DATA_W:0]   sum_red;
   logic              is_last;
   logic              rem_start;

   assign n_sat    = (cfg.term_count > TERM_LIMIT) ? TERM_LIMIT : cfg.term_count;
   assign coef_sel = cfg.coef[CNT_W'(idx_ff)];
   assign mul_a    = (state_ff == S_COEF) ? coef_sel : x_ff;
   assign product  = PROD_W'(mul_a) * PROD_W'(pw_ff);
   assign sum      = {1'b0, acc_ff} + {1'b0, rem_rsp.remainder};
   assign sum_red  = (sum >= {1'b0, cfg.modulus}) ? sum - {1'b0, cfg.modulus} : sum;
   assign is_last  = (CNT_W'(idx_ff) + CNT_W'(1)) == n_ff;

   assign rem_req.start    = rem_start;
   assign rem_req.dividend = product;
   assign rem_req.divisor  = cfg.modulus;

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_share_value = share_ff;

   always_comb begin
      state_in      = state_ff;
      x_in          = x_ff;
      pw_in         = pw_ff;
      acc_in        = acc_ff;
      idx_in        = idx_ff;
      n_in          = n_ff;
      share_in      = share_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rem_start     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               x_in   = req_point;
               pw_in  = DATA_W'(1);
               acc_in = '0;
               idx_in = '0;
               n_in   = n_sat;
               if (cfg.modulus == '0 || n_sat == '0) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_COEF;
               end
            end
         end
         S_COEF: begin
            rem_start = 1'b1;
            state_in  = S_COEF_WAIT;
         end
         S_COEF_WAIT: begin
            if (rem_rsp.done) begin
               acc_in = sum_red[DATA_W-1:0];
               if (is_last) begin
                  state_in = S_DONE;
               end else begin
                  // power times point goes straight into the unit
                  rem_start = 1'b1;
                  state_in  = S_POW_WAIT;
               end
            end
         end
         S_POW_WAIT: begin
            if (rem_rsp.done) begin
               pw_in    = rem_rsp.remainder;
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_COEF;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               share_in     = acc_ff;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff     <= x_in;
      pw_ff    <= pw_in;
      acc_ff   <= acc_in;
      idx_ff   <= idx_in;
      n_ff     <= n_in;
      share_ff <= share_in;
   end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import mpe_pkg::*;

   localparam int unsigned TERM_LIMIT = (MAX_TERMS_DEF < NUM_COEFS) ? MAX_TERMS_DEF : NUM_COEFS;
   localparam int unsigned COEF_IDX_W = $clog2(NUM_COEFS);
   localparam int RANDOM_POINTS = 650;
   localparam int DRAIN_CYCLES  = 400;
   localparam int STALL_LIMIT   = 4000;

   typedef struct {
      logic [DATA_W-1:0] point;
      logic [DATA_W-1:0] share;
   } share_type;

   typedef struct {
      csr_index_type     index;
      logic [DATA_W-1:0] data;
   } reg_write_type;

   logic              clock;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [DATA_W-1:0] req_point = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [DATA_W-1:0] rsp_share_value;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   csr_index_type     csr_index = CSR_MODULUS;
   logic [DATA_W-1:0] csr_data  = '0;

   logic [DATA_W-1:0] model_modulus;
   logic [CNT_W-1:0]  model_terms;
   logic [DATA_W-1:0] model_coef [NUM_COEFS];

   logic [DATA_W-1:0] point_queue [$];
   reg_write_type     reg_writes [$];
   share_type         pending_shares [$];

   int  points_outstanding = 0;
   int  writes_outstanding = 0;
   int  points_sent        = 0;
   int  shares_seen        = 0;
   int  settings           = 0;
   int  errors             = 0;
   int  req_gap            = 0;
   int  rsp_stall          = 0;
   int  quiet              = 0;
   bit  idling             = 1'b1;

   modular_polynomial_eval u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_point       (req_point),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_share_value (rsp_share_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic logic [DATA_W-1:0] poly_share(input logic [DATA_W-1:0] x);
      logic [63:0] q;
      logic [63:0] acc;
      logic [63:0] pw;
      int unsigned n;
      int unsigned i;
      q   = 64'(model_modulus);
      n   = 32'(model_terms);
      acc = 64'd0;
      pw  = 64'd1;
      if (n > TERM_LIMIT) n = TERM_LIMIT;
      if (q == 64'd0) return '0;
      for (i = 0; i < n; i++) begin
         acc = (acc + (64'(model_coef[COEF_IDX_W'(i)]) * pw) % q) % q;
         pw  = (pw * 64'(x)) % q;
      end
      return acc[DATA_W-1:0];
   endfunction

   // driver: register writes and points
   always @(posedge clock) begin : driver
      reg_write_type w;
      if (reset) begin
         req_valid     <= 1'b0;
         csr_valid     <= 1'b0;
         req_gap       = 0;
         model_modulus = MODULUS_RST;
         model_terms   = TERM_COUNT_RST;
         foreach (model_coef[k]) model_coef[k] = COEF_RST;
      end else begin
         if (!csr_valid || csr_ready) begin
            if (csr_valid) begin
               case (csr_index)
                  CSR_MODULUS:    model_modulus = csr_data;
                  CSR_TERM_COUNT: model_terms = csr_data[CNT_W-1:0];
                  default:        model_coef[COEF_IDX_W'(csr_index - CSR_COEF_ZERO)] = csr_data;
               endcase
               writes_outstanding--;
            end
            if (reg_writes.size() != 0) begin
               w = reg_writes.pop_front();
               csr_valid <= 1'b1;
               csr_index <= w.index;
               csr_data  <= w.data;
            end else begin
               csr_valid <= 1'b0;
            end
         end
         if (!req_valid || req_ready) begin
            if (req_valid) begin
               pending_shares.insert(pending_shares.size(),
                                     share_type'{req_point, poly_share(req_point)});
               points_outstanding--;
               points_sent++;
            end
            if (req_gap != 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (point_queue.size() != 0) begin
               if (idling && $urandom_range(0, 7) == 0) begin
                  req_gap = $urandom_range(0, 5);
                  req_valid <= 1'b0;
               end else begin
                  req_valid <= 1'b1;
                  req_point <= point_queue.pop_front();
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: result beats against the oldest expected share
   always @(posedge clock) begin : monitor
      share_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            shares_seen++;
            if (pending_shares.size() == 0) begin
               errors++;
               $display("%0t: unexpected share beat: expected none, actual %0d",
                        $time, rsp_share_value);
            end else begin
               want = pending_shares.pop_front();
               if (rsp_share_value !== want.share) begin
                  errors++;
                  $display("%0t: share_value mismatch at point %0d: expected %0d, actual %0d",
                           $time, want.point, want.share, rsp_share_value);
               end
            end
         end
         if (rsp_stall != 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else if (idling && $urandom_range(0, 9) == 0) begin
            rsp_stall = $urandom_range(0, 5);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, quiet);
            $display("** modular_polynomial_eval: FAILED **");
            $finish;
         end
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [DATA_W-1:0] data);
      reg_writes.insert(reg_writes.size(), reg_write_type'{idx, data});
      writes_outstanding++;
   endtask

   task automatic set_config(input cfg_type cfg);
      int k;
      write_reg(CSR_MODULUS, cfg.modulus);
      // upper data bits are don't-care for the term count
      write_reg(CSR_TERM_COUNT, DATA_W'($urandom & 32'hFFF8) | DATA_W'(cfg.term_count));
      for (k = 0; k < NUM_COEFS; k++) begin
         write_reg(csr_index_type'(CSR_COEF_ZERO + k), cfg.coef[k]);
      end
      while (writes_outstanding != 0) @(posedge clock);
      settings++;
   endtask

   task automatic send_point(input logic [DATA_W-1:0] p);
      point_queue.insert(point_queue.size(), p);
      points_outstanding++;
   endtask

   task automatic wait_idle();
      while (points_outstanding != 0 || pending_shares.size() != 0) @(posedge clock);
   endtask

   function automatic cfg_type random_cfg();
      cfg_type cfg;
      int k;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: cfg.modulus = 16'd0;
               1: cfg.modulus = 16'd1;
               2: cfg.modulus = 16'd2;
               default: cfg.modulus = 16'hFFFF;
            endcase
         end
         1: cfg.modulus = DATA_W'($urandom_range(2, 300));
         default: cfg.modulus = DATA_W'($urandom_range(2, 65535));
      endcase
      if ($urandom_range(0, 9) < 2) cfg.term_count = CNT_W'($urandom_range(0, 7));
      else cfg.term_count = CNT_W'($urandom_range(1, 6));
      for (k = 0; k < NUM_COEFS; k++) begin
         case ($urandom_range(0, 7))
            0: cfg.coef[k] = 16'hFFFF;
            1: cfg.coef[k] = 16'd0;
            default: cfg.coef[k] = DATA_W'($urandom);
         endcase
      end
      return cfg;
   endfunction

   function automatic logic [DATA_W-1:0] random_point();
      case ($urandom_range(0, 15))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'd1;
         3: return model_modulus - 16'd1;
         4: return model_modulus;
         default: return DATA_W'($urandom);
      endcase
   endfunction

   function automatic cfg_type fill_cfg(input logic [DATA_W-1:0] q, input logic [CNT_W-1:0] tc);
      cfg_type cfg;
      cfg = random_cfg();
      cfg.modulus    = q;
      cfg.term_count = tc;
      return cfg;
   endfunction

   initial begin : stimulus
      cfg_type cfg;
      int remaining;
      int count;
      int k;
      wait (!reset);
      @(posedge clock);

      // reset values of the registers
      send_point(16'd0);
      send_point(16'hFFFF);
      send_point(16'd1);
      wait_idle();

      // modulus and all coefficients at their maximum, six terms
      cfg = fill_cfg(16'hFFFF, 3'd6);
      for (k = 0; k < NUM_COEFS; k++) cfg.coef[k] = 16'hFFFF;
      set_config(cfg);
      send_point(16'd0);
      send_point(16'd1);
      send_point(16'hFFFE);
      send_point(16'hFFFF);
      wait_idle();

      // modulus zero
      set_config(fill_cfg(16'd0, 3'd6));
      send_point(16'd12345);
      send_point(16'hFFFF);
      wait_idle();

      // modulus one
      set_config(fill_cfg(16'd1, 3'd6));
      send_point(16'hFFFF);
      send_point(16'd2);
      wait_idle();

      // empty sum
      set_config(fill_cfg(16'd10079, 3'd0));
      send_point(16'd77);
      wait_idle();

      // term count above the maximum saturates
      set_config(fill_cfg(16'd65521, 3'd7));
      send_point(16'd3);
      send_point(16'hFFFF);
      wait_idle();

      // smallest useful modulus, constant term only
      cfg = fill_cfg(16'd2, 3'd1);
      for (k = 0; k < NUM_COEFS; k++) cfg.coef[k] = 16'd0;
      cfg.coef[0] = 16'hFFFF;
      set_config(cfg);
      send_point(16'd0);
      send_point(16'd1);
      wait_idle();

      // highest term alone
      cfg = fill_cfg(16'hFFFF, 3'd6);
      for (k = 0; k < NUM_COEFS; k++) cfg.coef[k] = 16'd0;
      cfg.coef[NUM_COEFS-1] = 16'hFFFF;
      set_config(cfg);
      send_point(16'hFFFE);
      send_point(16'hFFFD);
      wait_idle();

      // point equal to and just under the modulus
      set_config(fill_cfg(16'd40000, 3'd6));
      send_point(16'd40000);
      send_point(16'd39999);
      wait_idle();

      remaining = RANDOM_POINTS;
      while (remaining > 0) begin
         count = $urandom_range(15, 40);
         if (count >= remaining) begin
            count  = remaining;
            idling = 1'b0;
         end
         set_config(random_cfg());
         for (k = 0; k < count; k++) send_point(random_point());
         wait_idle();
         remaining -= count;
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_shares.size() != 0) begin
         errors++;
         $display("%0t: shares left over: expected 0, actual %0d", $time, pending_shares.size());
      end
      $display("%0d points evaluated under %0d register settings, %0d shares compared",
               points_sent, settings, shares_seen);
      $display("settings took in moduli 0, 1, 2 and 65535, no terms and saturated term counts");
      if (errors == 0) begin
         $display("** modular_polynomial_eval: PASSED **");
      end else begin
         $display("** modular_polynomial_eval: FAILED **");
      end
      $finish;
   end

endmodule
